>>> rtl/ged_pkg.sv
`timescale 1ns / 1ps

package ged_pkg;

    // Register file layout
    localparam int REG_LINES       = 16;
    localparam int MODE_BITS       = 3;
    localparam int MODES_WIDTH     = REG_LINES * MODE_BITS;
    localparam int TICKS_WIDTH     = 14;
    localparam int CFG_DATA_WIDTH  = MODES_WIDTH;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int LINE_WIDTH      = 4;

    localparam logic [LINE_WIDTH-1:0] LINE_MASK = 4'h0F;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_LINES   = 16;
    localparam int DEF_COUNT_WIDTH = 14;

    // Reset value of the debounce delay
    localparam logic [TICKS_WIDTH-1:0] TICKS_RESET = 14'd20;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TRIGGER_MODES  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HANDLER_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_EN    = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_TICKS = 2'd3;

    // Input transaction kinds
    localparam logic [1:0] KIND_TRIGGER = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_ARM     = 2'd2;

    // Per-line trigger modes
    localparam logic [MODE_BITS-1:0] TRIG_NONE       = 3'd0;
    localparam logic [MODE_BITS-1:0] TRIG_FALLING    = 3'd1;
    localparam logic [MODE_BITS-1:0] TRIG_RISING     = 3'd2;
    localparam logic [MODE_BITS-1:0] TRIG_BOTH       = 3'd3;
    localparam logic [MODE_BITS-1:0] TRIG_LEVEL_LOW  = 3'd4;
    localparam logic [MODE_BITS-1:0] TRIG_LEVEL_HIGH = 3'd5;

    typedef struct packed {
        logic [1:0]            mode;
        logic [LINE_WIDTH-1:0] line;
        logic                  pin_level;
        logic [REG_LINES-1:0]  pin_levels;
    } in_item_t;

    typedef struct packed {
        logic [LINE_WIDTH-1:0] event_line;
        logic                  event_level;
        logic                  last;
    } out_item_t;

endpackage

>>> rtl/gpio_edge_interrupt_debouncer.sv
`timescale 1ns / 1ps

// External interrupt block with per-line debounce.
// Configuration is written through cfg_we / cfg_index / cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce. A
// write takes effect at the clock edge where cfg_we is high. The s_ channel takes
// one transaction at a time: a line trigger, a time tick or an arm request.
// s_ready is high only while the sequencer is idle. Results leave on the
// m_ channel, with last set on the final result caused by an input transaction.
// A trigger or arm is accepted, executed, then its held result is drained; s_ready
// returns when the final result, if any, is in the output register (a both-edge
// mismatch puts one ahead of it in the execute step). A tick walks the lines
// through one shared decrement and compare unit, one line per cycle while the
// output side keeps up. One result is held back until the next is known, so that
// last can be set on it.
// When the receiver stalls, the sequencer waits at the first point where it
// needs the output register and resumes when m_ready frees it.
// Reset clears all countdowns and expected levels, and loads the registers
// with their reset values (debounce delay 20 ticks).
module gpio_edge_interrupt_debouncer
    import ged_pkg::*;
#(
    parameter int NUM_LINES   = DEF_NUM_LINES,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  in_item_t                   s_data,

    output logic                       m_valid,
    input  logic                       m_ready,
    output out_item_t                  m_data
);

    localparam int LINE_IW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int LOAD_W  = (COUNT_WIDTH > TICKS_WIDTH) ? COUNT_WIDTH : TICKS_WIDTH;
    localparam logic [LOAD_W-1:0] COUNT_MAX_EXT = LOAD_W'({COUNT_WIDTH{1'b1}});
    localparam logic [LINE_IW-1:0] SCAN_LAST = LINE_IW'(NUM_LINES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t                    state_reg, state_next;
    in_item_t                  item_reg, item_next;
    logic [LINE_IW-1:0]        scan_reg, scan_next;

    logic [MODES_WIDTH-1:0]    modes_reg, modes_next;
    logic [REG_LINES-1:0]      hen_reg, hen_next;
    logic [REG_LINES-1:0]      den_reg, den_next;
    logic [TICKS_WIDTH-1:0]    ticks_reg, ticks_next;

    logic [NUM_LINES-1:0]      exp_reg, exp_next;
    logic [COUNT_WIDTH-1:0]    cnt_reg  [NUM_LINES];
    logic [COUNT_WIDTH-1:0]    cnt_next [NUM_LINES];

    logic                      hold_valid_reg, hold_valid_next;
    logic [LINE_WIDTH-1:0]     hold_line_reg, hold_line_next;
    logic                      hold_level_reg, hold_level_next;

    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_reg, out_next;

    // Per-line views of the register file; lines past the register bits read as off
    logic [NUM_LINES-1:0]      hen_vec;
    logic [NUM_LINES-1:0]      den_vec;
    logic [NUM_LINES-1:0]      pin_vec;
    logic [MODE_BITS-1:0]      mode_vec [NUM_LINES];

    for (genvar g = 0; g < NUM_LINES; g++) begin : g_line
        if (g < REG_LINES) begin : g_reg
            assign hen_vec[g]  = hen_reg[g];
            assign den_vec[g]  = den_reg[g];
            assign pin_vec[g]  = item_reg.pin_levels[g];
            assign mode_vec[g] = modes_reg[g*MODE_BITS +: MODE_BITS];
        end else begin : g_none
            assign hen_vec[g]  = 1'b0;
            assign den_vec[g]  = 1'b0;
            assign pin_vec[g]  = 1'b0;
            assign mode_vec[g] = TRIG_NONE;
        end
    end

    logic                      out_free;
    logic                      line_ok;
    logic [LINE_IW-1:0]        ln_idx;
    logic [MODE_BITS-1:0]      ln_mode;
    logic                      ln_exp_arm;
    logic                      ln_exp;
    logic                      self_trig;
    logic                      do_trig;
    logic [LOAD_W-1:0]         load_ext;
    logic [COUNT_WIDTH-1:0]    load_val;
    logic [COUNT_WIDTH-1:0]    scan_cnt;
    logic [COUNT_WIDTH-1:0]    scan_dec;
    logic                      scan_fire;
    logic                      scan_stall;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Clamp the debounce delay into the counter range
    always_comb begin
        load_ext = LOAD_W'(ticks_reg);
        if (load_ext == '0) begin
            load_ext = LOAD_W'(1);
        end
        if (load_ext > COUNT_MAX_EXT) begin
            load_ext = COUNT_MAX_EXT;
        end
        load_val = COUNT_WIDTH'(load_ext);
    end

    // Decode the line named by a trigger or arm transaction
    always_comb begin
        line_ok   = (32'(item_reg.line) < NUM_LINES);
        ln_idx    = LINE_IW'(item_reg.line);
        ln_mode   = mode_vec[ln_idx];
        ln_exp_arm = exp_reg[ln_idx];
        case (ln_mode) inside
            TRIG_FALLING, TRIG_LEVEL_LOW:  ln_exp_arm = 1'b0;
            TRIG_RISING, TRIG_LEVEL_HIGH:  ln_exp_arm = 1'b1;
            TRIG_BOTH:                     ln_exp_arm = ~item_reg.pin_level;
            default:                       ln_exp_arm = exp_reg[ln_idx];
        endcase
        self_trig = ((ln_mode == TRIG_LEVEL_LOW)  && !item_reg.pin_level) ||
                    ((ln_mode == TRIG_LEVEL_HIGH) &&  item_reg.pin_level);
        ln_exp    = (item_reg.mode == KIND_ARM) ? ln_exp_arm : exp_reg[ln_idx];
        do_trig   = (item_reg.mode == KIND_TRIGGER) || self_trig;
    end

    // Shared decrement and compare unit for the tick scan
    always_comb begin
        scan_cnt   = cnt_reg[scan_reg];
        scan_dec   = scan_cnt - COUNT_WIDTH'(1);
        scan_fire  = (scan_cnt != '0) && (scan_dec == '0) && hen_vec[scan_reg] &&
                     (pin_vec[scan_reg] == exp_reg[scan_reg]);
        out_free   = !out_valid_reg || m_ready;
        scan_stall = scan_fire && hold_valid_reg && !out_free;
    end

    // Sequencer and datapath next state
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        scan_next       = scan_reg;
        modes_next      = modes_reg;
        hen_next        = hen_reg;
        den_next        = den_reg;
        ticks_next      = ticks_reg;
        exp_next        = exp_reg;
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_line_next  = hold_line_reg;
        hold_level_next = hold_level_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        // Drop the output once taken
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        // Register writes
        if (cfg_we) begin
            unique case (cfg_index)
                REG_TRIGGER_MODES:  modes_next = cfg_wdata;
                REG_HANDLER_ENABLE: hen_next   = cfg_wdata[REG_LINES-1:0];
                REG_DEBOUNCE_EN:    den_next   = cfg_wdata[REG_LINES-1:0];
                REG_DEBOUNCE_TICKS: ticks_next = cfg_wdata[TICKS_WIDTH-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    scan_next = '0;
                    if (s_data.mode == KIND_TICK) begin
                        state_next = ST_SCAN;
                    end else if (((s_data.mode == KIND_TRIGGER) ||
                                  (s_data.mode == KIND_ARM)) &&
                                 (32'(s_data.line) < NUM_LINES)) begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC: begin
                if (!line_ok) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    cnt_next[ln_idx] = '0;
                    if (hen_vec[ln_idx]) begin
                        if (item_reg.mode == KIND_ARM) begin
                            exp_next[ln_idx] = ln_exp_arm;
                        end
                        if (do_trig) begin
                            if (den_vec[ln_idx]) begin
                                cnt_next[ln_idx] = load_val;
                            end else if ((ln_mode == TRIG_BOTH) &&
                                         (item_reg.pin_level != ln_exp)) begin
                                // Report the expectation, hold the actual level
                                out_valid_next        = 1'b1;
                                out_next.event_line   = item_reg.line & LINE_MASK;
                                out_next.event_level  = ln_exp;
                                out_next.last         = 1'b0;
                                hold_valid_next       = 1'b1;
                                hold_line_next        = item_reg.line & LINE_MASK;
                                hold_level_next       = item_reg.pin_level;
                            end else begin
                                hold_valid_next = 1'b1;
                                hold_line_next  = item_reg.line & LINE_MASK;
                                hold_level_next = ln_exp;
                                if (ln_mode == TRIG_BOTH) begin
                                    exp_next[ln_idx] = ~ln_exp;
                                end
                            end
                        end
                    end
                    state_next = ST_FLUSH;
                end
            end

            ST_SCAN: begin
                if (!scan_stall) begin
                    if (scan_cnt != '0) begin
                        cnt_next[scan_reg] = scan_dec;
                    end
                    if (scan_fire) begin
                        if (hold_valid_reg) begin
                            out_valid_next       = 1'b1;
                            out_next.event_line  = hold_line_reg;
                            out_next.event_level = hold_level_reg;
                            out_next.last        = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_line_next  = LINE_WIDTH'(scan_reg) & LINE_MASK;
                        hold_level_next = pin_vec[scan_reg];
                        if (mode_vec[scan_reg] == TRIG_BOTH) begin
                            exp_next[scan_reg] = ~exp_reg[scan_reg];
                        end
                    end
                    if (scan_reg == SCAN_LAST) begin
                        state_next = ST_FLUSH;
                    end else begin
                        scan_next = scan_reg + LINE_IW'(1);
                    end
                end
            end

            ST_FLUSH: begin
                // Release the held result as the final one of this transaction
                if (!hold_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next       = 1'b1;
                    out_next.event_line  = hold_line_reg;
                    out_next.event_level = hold_level_reg;
                    out_next.last        = 1'b1;
                    hold_valid_next      = 1'b0;
                    state_next           = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state, line state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scan_reg       <= '0;
            modes_reg      <= '0;
            hen_reg        <= '0;
            den_reg        <= '0;
            ticks_reg      <= TICKS_RESET;
            exp_reg        <= '0;
            for (int i = 0; i < NUM_LINES; i++) begin
                cnt_reg[i] <= '0;
            end
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            modes_reg      <= modes_next;
            hen_reg        <= hen_next;
            den_reg        <= den_next;
            ticks_reg      <= ticks_next;
            exp_reg        <= exp_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        item_reg       <= item_next;
        hold_line_reg  <= hold_line_next;
        hold_level_reg <= hold_level_next;
        out_reg        <= out_next;
    end

endmodule

>>> sim/ged_event_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port of the interrupt block, keeps
// its own copy of the line state, and compares every result transaction with
// the oldest predicted event.
module ged_event_checker
    import ged_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  in_item_t                   s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  out_item_t                  m_data,
    output int                         mismatches,
    output int                         outstanding
);

    localparam int NLINES    = DEF_NUM_LINES;
    localparam int COUNT_MAX = (1 << DEF_COUNT_WIDTH) - 1;

    // Shadow registers
    logic [MODES_WIDTH-1:0] line_modes;
    logic [REG_LINES-1:0]   handler_en;
    logic [REG_LINES-1:0]   debounce_en;
    logic [TICKS_WIDTH-1:0] delay_ticks;

    // Shadow line state
    logic                       expect_lvl [NLINES];
    logic [DEF_COUNT_WIDTH-1:0] countdown  [NLINES];

    out_item_t pending_events[$];
    out_item_t burst[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [MODE_BITS-1:0] mode_of(input int ln);
        return line_modes[MODE_BITS*ln +: MODE_BITS];
    endfunction

    task automatic add_event(input int ln, input logic lvl);
        out_item_t ev;
        ev.event_line  = LINE_WIDTH'(ln);
        ev.event_level = lvl;
        ev.last        = 1'b0;
        burst.push_back(ev);
    endtask

    // Trigger one line: cancel its countdown, then report or start debounce
    task automatic fire_line(input int ln, input logic lvl);
        int load;
        countdown[ln] = '0;
        if (!handler_en[ln]) return;
        if (debounce_en[ln]) begin
            load = int'(delay_ticks);
            if (load == 0) load = 1;
            if (load > COUNT_MAX) load = COUNT_MAX;
            countdown[ln] = DEF_COUNT_WIDTH'(load);
            return;
        end
        add_event(ln, expect_lvl[ln]);
        if (mode_of(ln) == TRIG_BOTH) begin
            if (lvl != expect_lvl[ln]) begin
                add_event(ln, lvl);
            end else begin
                expect_lvl[ln] = ~expect_lvl[ln];
            end
        end
    endtask

    // Work out the events that one input transaction causes
    task automatic apply_item(input in_item_t it);
        logic [MODE_BITS-1:0] m;
        int ln;
        burst.delete();
        ln = int'(it.line);
        case (it.mode)
            KIND_TICK: begin
                for (int i = 0; i < NLINES; i++) begin
                    if (countdown[i] != '0) begin
                        countdown[i] = countdown[i] - DEF_COUNT_WIDTH'(1);
                        if (countdown[i] == '0 && handler_en[i]
                                && it.pin_levels[i] == expect_lvl[i]) begin
                            add_event(i, it.pin_levels[i]);
                            if (mode_of(i) == TRIG_BOTH) expect_lvl[i] = ~expect_lvl[i];
                        end
                    end
                end
            end
            KIND_TRIGGER: begin
                if (ln < NLINES) fire_line(ln, it.pin_level);
            end
            KIND_ARM: begin
                if (ln < NLINES) begin
                    m = mode_of(ln);
                    countdown[ln] = '0;
                    if (handler_en[ln]) begin
                        case (m)
                            TRIG_FALLING, TRIG_LEVEL_LOW: expect_lvl[ln] = 1'b0;
                            TRIG_RISING, TRIG_LEVEL_HIGH: expect_lvl[ln] = 1'b1;
                            TRIG_BOTH:                    expect_lvl[ln] = ~it.pin_level;
                            default: ;
                        endcase
                        if ((m == TRIG_LEVEL_LOW && !it.pin_level)
                                || (m == TRIG_LEVEL_HIGH && it.pin_level)) begin
                            fire_line(ln, it.pin_level);
                        end
                    end
                end
            end
            default: ;
        endcase
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[k]) pending_events.push_back(burst[k]);
    endtask

    // Compare results first, then fold in register writes and new transactions
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            line_modes  = '0;
            handler_en  = '0;
            debounce_en = '0;
            delay_ticks = TICKS_RESET;
            for (int i = 0; i < NLINES; i++) begin
                expect_lvl[i] = 1'b0;
                countdown[i]  = '0;
            end
            pending_events.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_events.size() == 0) begin
                    report($sformatf("unexpected event line %0d level %0d last %0d",
                                     m_data.event_line, m_data.event_level, m_data.last));
                end else begin
                    want = pending_events.pop_front();
                    if (m_data.event_line != want.event_line)
                        report($sformatf("event_line %0d, predicted %0d",
                                         m_data.event_line, want.event_line));
                    if (m_data.event_level != want.event_level)
                        report($sformatf("event_level %0d on line %0d, predicted %0d",
                                         m_data.event_level, want.event_line,
                                         want.event_level));
                    if (m_data.last != want.last)
                        report($sformatf("last %0d on line %0d, predicted %0d",
                                         m_data.last, want.event_line, want.last));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_TRIGGER_MODES:  line_modes  = cfg_wdata[MODES_WIDTH-1:0];
                    REG_HANDLER_ENABLE: handler_en  = cfg_wdata[REG_LINES-1:0];
                    REG_DEBOUNCE_EN:    debounce_en = cfg_wdata[REG_LINES-1:0];
                    REG_DEBOUNCE_TICKS: delay_ticks = cfg_wdata[TICKS_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) apply_item(s_data);
        end
        outstanding = pending_events.size();
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ged_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 460;
    localparam int PHASES         = 5;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    in_item_t                   s_data;
    logic                       m_valid;
    logic                       m_ready;
    out_item_t                  m_data;

    int   mismatches;
    int   outstanding;
    int   idle_cycles;
    logic steady;

    gpio_edge_interrupt_debouncer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    ged_event_checker i_event_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Stall the result channel at random, except during the steady stretch
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 34);
    end

    // End the run if no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("gpio_edge_interrupt_debouncer regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic in_item_t make_item(input logic [1:0] kind, input int ln,
                                           input logic lvl, input logic [15:0] pins);
        in_item_t it;
        it.mode       = kind;
        it.line       = LINE_WIDTH'(ln);
        it.pin_level  = lvl;
        it.pin_levels = pins;
        return it;
    endfunction

    function automatic in_item_t random_item(input int tick_pct);
        in_item_t it;
        int       r;
        it.line       = LINE_WIDTH'($urandom_range(0, 15));
        it.pin_level  = 1'($urandom_range(0, 1));
        it.pin_levels = REG_LINES'($urandom_range(0, 65535));
        r = int'($urandom_range(0, 99));
        if (r < tick_pct) begin
            it.mode = KIND_TICK;
        end else if (r >= 96) begin
            it.mode = KIND_UNUSED;
        end else if ($urandom_range(0, 2) == 0) begin
            it.mode = KIND_ARM;
        end else begin
            it.mode = KIND_TRIGGER;
        end
        return it;
    endfunction

    // Offer one transaction, with a random gap ahead of it; return at a falling edge
    task automatic send(input in_item_t it);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 34) gap = int'($urandom_range(1, 2));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Hold the input until every predicted event has come out
    task automatic wait_events;
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // Drain, then let a full tick scan finish before the block is touched
    task automatic quiesce;
        wait_events();
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write one register; keep the enable up when another write follows
    task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val, input bit lower);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        if (lower) cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [MODES_WIDTH-1:0] modes,
                             input logic [REG_LINES-1:0] handlers,
                             input logic [REG_LINES-1:0] debounced,
                             input logic [TICKS_WIDTH-1:0] ticks);
        cfg_write(REG_TRIGGER_MODES, CFG_DATA_WIDTH'(modes), 1'b0);
        cfg_write(REG_HANDLER_ENABLE, CFG_DATA_WIDTH'(handlers), 1'b0);
        cfg_write(REG_DEBOUNCE_EN, CFG_DATA_WIDTH'(debounced), 1'b0);
        cfg_write(REG_DEBOUNCE_TICKS, CFG_DATA_WIDTH'(ticks), 1'b1);
    endtask

    initial begin
        logic [MODES_WIDTH-1:0] mode_pattern;
        logic [MODES_WIDTH-1:0] modes;
        logic [REG_LINES-1:0]   handlers;
        logic [REG_LINES-1:0]   debounced;
        logic [TICKS_WIDTH-1:0] ticks;
        in_item_t               it;
        int                     tick_pct;
        int                     sent;
        int                     per_phase;

        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        steady      = 1'b0;
        idle_cycles = 0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset configuration: no handlers, so nothing reports
        send(make_item(KIND_TRIGGER, 0, 1'b1, 16'h0000));
        send(make_item(KIND_TICK, 0, 1'b0, 16'hFFFF));
        send(make_item(KIND_ARM, 15, 1'b1, 16'h0000));
        send(make_item(KIND_UNUSED, 15, 1'b1, 16'hFFFF));

        // Line i gets mode i mod 8; the upper eight lines are debounced, zero delay
        quiesce();
        for (int i = 0; i < REG_LINES; i++)
            mode_pattern[MODE_BITS*i +: MODE_BITS] = MODE_BITS'(i % 8);
        configure(mode_pattern, 16'hFFFF, 16'hFF00, '0);

        // Both edges: mismatch reports twice, match toggles the expectation
        send(make_item(KIND_ARM, 3, 1'b0, 16'h0000));
        send(make_item(KIND_TRIGGER, 3, 1'b0, 16'h0000));
        send(make_item(KIND_TRIGGER, 3, 1'b1, 16'h0000));
        // Active level modes trigger themselves on arm
        send(make_item(KIND_ARM, 4, 1'b0, 16'h0000));
        send(make_item(KIND_ARM, 5, 1'b1, 16'h0000));
        // Falling and rising expectations
        send(make_item(KIND_ARM, 1, 1'b1, 16'h0000));
        send(make_item(KIND_TRIGGER, 1, 1'b1, 16'h0000));
        send(make_item(KIND_ARM, 2, 1'b0, 16'h0000));
        send(make_item(KIND_TRIGGER, 2, 1'b0, 16'h0000));
        // Undefined and none modes still report the expectation
        send(make_item(KIND_TRIGGER, 6, 1'b1, 16'h0000));
        send(make_item(KIND_TRIGGER, 0, 1'b1, 16'h0000));
        // Zero delay loads one tick; two lines expire on the same tick
        send(make_item(KIND_TRIGGER, 11, 1'b1, 16'h0000));
        send(make_item(KIND_TRIGGER, 15, 1'b0, 16'h0000));
        send(make_item(KIND_TICK, 0, 1'b0, 16'h0000));
        // Debounced level high armed with the pin high
        send(make_item(KIND_ARM, 13, 1'b1, 16'h0000));
        send(make_item(KIND_TICK, 0, 1'b0, 16'hFFFF));
        // Arm cancels a pending countdown
        send(make_item(KIND_TRIGGER, 9, 1'b0, 16'h0000));
        send(make_item(KIND_ARM, 9, 1'b1, 16'h0000));
        send(make_item(KIND_TICK, 0, 1'b0, 16'h0000));
        send(make_item(KIND_UNUSED, 15, 1'b1, 16'hFFFF));

        // Random phases, each under a fresh configuration
        per_phase = RANDOM_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            quiesce();
            modes     = MODES_WIDTH'({$urandom, $urandom});
            handlers  = REG_LINES'($urandom_range(0, 65535));
            debounced = REG_LINES'($urandom_range(0, 65535));
            ticks     = TICKS_WIDTH'($urandom_range(1, 8));
            tick_pct  = 30;
            steady    = 1'b0;
            case (p)
                0: begin
                    ticks  = TICKS_WIDTH'(1);
                    steady = 1'b1;
                end
                1: begin
                    handlers  = 16'hFFFF;
                    debounced = 16'h0000;
                end
                2: begin
                    debounced = 16'hFFFF;
                    ticks     = TICKS_WIDTH'($urandom_range(1, 4));
                    tick_pct  = 55;
                end
                3: begin
                    handlers = 16'hFFFF;
                    ticks    = '1;
                end
                default: ;
            endcase
            configure(modes, handlers | 16'h8001, debounced, ticks);

            sent = 0;
            while (sent < per_phase) begin
                it = random_item(tick_pct);
                send(it);
                if (it.mode != KIND_UNUSED) sent++;
                if (p == 3 && sent == per_phase / 2) wait_events();
            end
        end

        quiesce();
        if (mismatches == 0) begin
            $display("gpio_edge_interrupt_debouncer regression: pass");
        end else begin
            $display("gpio_edge_interrupt_debouncer regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/ged_pkg.sv
rtl/gpio_edge_interrupt_debouncer.sv
sim/ged_event_checker.sv
sim/testbench.sv
